>>> sv/iqp_pkg.sv
`timescale 1ns / 1ps
// iqp_pkg: shared types and constants of the IQ pulse datagram packetizer.
// No dependencies; every module of the block refers to it by scoped names.
package iqp_pkg;

	localparam int unsigned HDR_WORDS = 43;         // 86-byte header in 16-bit words
	localparam logic [15:0] HDR_BYTES = 16'd86;
	localparam logic [15:0] GATE_BYTES = 16'd4;
	localparam logic [15:0] MSG_TYPE = 16'h0001;
	localparam logic [31:0] BEAM_INDEX = 32'd200;
	localparam logic [15:0] GATES_RESET = 16'd1024;
	localparam logic [15:0] MAX_BYTES_RESET = 16'd1472;

	localparam int unsigned DIV_W = 16;
	localparam int unsigned STEP_W = $clog2(DIV_W);

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

	localparam logic KIND_DESC = 1'b0;
	localparam logic KIND_GATE = 1'b1;

	typedef enum logic {
		CFG_GATES = 1'b0,
		CFG_MAX_BYTES = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic kind;
		logic signed [63:0] seconds;
		logic [29:0] nanoseconds;
		logic [63:0] dwell_number;
		logic [15:0] beam_in_dwell;
		logic [15:0] visit_in_beam;
		logic [31:0] u_bits;
		logic [31:0] v_bits;
		logic transmit_h;
		logic copolar_receive;
		logic signed [15:0] i_value;
		logic signed [15:0] q_value;
	} in_t;

	typedef struct packed {
		logic [15:0] word;
		logic last_in_packet;
	} out_t;

	typedef enum logic [1:0] {
		CMD_DESC,
		CMD_GATE,
		CMD_CLOSE
	} cmd_kind_t;

	// One queue entry: a descriptor to latch, a gate to send, or a pulse close
	typedef struct packed {
		cmd_kind_t kind;
		in_t item;
		logic hdr;          // gate opens a packet: header goes first
		logic first;        // first packet of the pulse
		logic [15:0] count; // gates announced in the header
		logic last;         // final gate of the packet
		logic close;        // pulse ends after this gate
	} cmd_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> sv/iq_pulse_udp_packetizer.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake               Payload
// in        in   in_valid / in_ready     iqp_pkg::in_t  (descriptor or one IQ gate)
// out       out  out_valid / out_ready   iqp_pkg::out_t (16-bit word, end of datagram)
// cfg       in   cfg_we                  cfg_index selects register, cfg_data value
//
// One output word per cycle while out_ready is high and gates wait: a gate gives I and Q,
// plus 43 header words if it opens a packet; descriptors and dropped gates give no words.
// The front takes one transaction per cycle while the 4-entry command queue has room.
// The packet split runs on a shared bit-serial divider: after reset and after every
// register write, in_ready stays low while it recomputes.
// arst_n clears control, counters and held descriptor; out_ready low stalls the back,
// and the front keeps taking transactions until the queue fills.
// Depends on iqp_pkg, iqp_front, iqp_div, iqp_fifo, iqp_back.
module iq_pulse_udp_packetizer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input iqp_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output iqp_pkg::out_t out_data,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data
);

	iqp_pkg::div_req_t div_req;
	iqp_pkg::div_rsp_t div_rsp;
	iqp_pkg::cmd_t push_cmd;
	iqp_pkg::cmd_t head;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	iqp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.div_req(div_req),
		.div_rsp(div_rsp),
		.push(push),
		.push_cmd(push_cmd),
		.q_full(q_full)
	);

	iqp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	iqp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.full(q_full),
		.empty(q_empty),
		.head(head)
	);

	iqp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

>>> sv/iqp_div.sv
`timescale 1ns / 1ps
// iqp_div: restoring divider, one quotient bit per cycle.
// Depends on iqp_pkg for widths and the request/response structs.
module iqp_div (
	input logic clk,
	input logic arst_n,
	input iqp_pkg::div_req_t req,
	output iqp_pkg::div_rsp_t rsp
);

	logic busy_q;
	logic done_q;
	logic [iqp_pkg::STEP_W-1:0] step_q;
	logic [iqp_pkg::DIV_W:0] rem_q;
	logic [iqp_pkg::DIV_W:0] dvs_q;
	logic [iqp_pkg::DIV_W-1:0] quo_q;
	logic [iqp_pkg::DIV_W+1:0] trial;
	logic fits;

	assign trial = {rem_q, quo_q[iqp_pkg::DIV_W-1]};
	assign fits = trial >= {1'b0, dvs_q};

	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == iqp_pkg::STEP_W'(iqp_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (iqp_pkg::DIV_W + 1)'(trial - {1'b0, dvs_q})
				: trial[iqp_pkg::DIV_W:0];
			quo_q <= {quo_q[iqp_pkg::DIV_W-2:0], fits};
		end
	end

endmodule

>>> sv/iqp_fifo.sv
`timescale 1ns / 1ps
// iqp_fifo: short show-ahead command queue between front and back.
// Depends on iqp_pkg for cmd_t and the depth.
module iqp_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input iqp_pkg::cmd_t push_cmd,
	input logic pop,
	output logic full,
	output logic empty,
	output iqp_pkg::cmd_t head
);

	iqp_pkg::cmd_t mem_q [iqp_pkg::FIFO_DEPTH];
	logic [iqp_pkg::PTR_W-1:0] wr_q;
	logic [iqp_pkg::PTR_W-1:0] rd_q;
	logic [iqp_pkg::PTR_W:0] cnt_q;

	assign full = cnt_q == (iqp_pkg::PTR_W + 1)'(iqp_pkg::FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

>>> sv/iqp_front.sv
`timescale 1ns / 1ps
// iqp_front: configuration registers, packet split, pulse tracking and
// classification of input transactions into queue commands. Depends on iqp_pkg.
module iqp_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input iqp_pkg::in_t in_data,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data,
	output iqp_pkg::div_req_t div_req,
	input iqp_pkg::div_rsp_t div_rsp,
	output logic push,
	output iqp_pkg::cmd_t push_cmd,
	input logic q_full
);

	typedef enum logic [1:0] {
		SPL_LOAD,
		SPL_PACKETS,
		SPL_PER,
		SPL_READY
	} spl_state_t;

	spl_state_t spl_q;
	logic [15:0] gates_q;
	logic [15:0] max_bytes_q;
	logic [15:0] per_q;
	logic [15:0] gate_index_q;
	logic [15:0] left_q;
	logic open_q;

	logic [13:0] max_gates;
	logic accept;
	logic is_gate;
	logic pkt_start;
	logic end_of_pulse;
	logic [15:0] remain;
	logic [15:0] count;
	logic [15:0] left_eff;
	logic [15:0] left_next;
	logic [15:0] index_next;
	logic last;
	logic close;

	// split depends on the registers only: recomputed after reset and each write
	assign max_gates = (max_bytes_q < iqp_pkg::HDR_BYTES + iqp_pkg::GATE_BYTES) ? 14'd1
		: 14'((max_bytes_q - iqp_pkg::HDR_BYTES) / iqp_pkg::GATE_BYTES);

	always_comb begin
		div_req.start = (spl_q == SPL_LOAD) || (spl_q == SPL_PACKETS && div_rsp.done);
		div_req.dividend = (spl_q == SPL_LOAD) ? gates_q : gates_q - 16'd1;
		div_req.divisor = (spl_q == SPL_LOAD) ? {3'b000, max_gates}
			: {1'b0, div_rsp.quotient} + 17'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spl_q <= SPL_LOAD;
			per_q <= '0;
		end else if (cfg_we) begin
			spl_q <= SPL_LOAD;
		end else begin
			unique case (spl_q)
				SPL_LOAD: spl_q <= SPL_PACKETS;
				SPL_PACKETS: begin
					if (div_rsp.done) begin
						spl_q <= SPL_PER;
					end
				end
				SPL_PER: begin
					if (div_rsp.done) begin
						spl_q <= SPL_READY;
						per_q <= div_rsp.quotient + 16'd1;
					end
				end
				SPL_READY: spl_q <= SPL_READY;
				default: spl_q <= SPL_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gates_q <= iqp_pkg::GATES_RESET;
			max_bytes_q <= iqp_pkg::MAX_BYTES_RESET;
		end else if (cfg_we) begin
			unique case (iqp_pkg::cfg_idx_t'(cfg_index))
				iqp_pkg::CFG_GATES: gates_q <= cfg_data;
				iqp_pkg::CFG_MAX_BYTES: max_bytes_q <= cfg_data;
				default: gates_q <= gates_q;
			endcase
		end
	end

	assign in_ready = (spl_q == SPL_READY) && !q_full;
	assign accept = in_valid && in_ready;
	assign is_gate = in_data.kind == iqp_pkg::KIND_GATE;

	assign pkt_start = left_q == 16'd0;
	assign end_of_pulse = gate_index_q >= gates_q;
	assign remain = gates_q - gate_index_q;
	assign count = (per_q < remain) ? per_q : remain;
	assign left_eff = pkt_start ? count : left_q;
	assign left_next = left_eff - 16'd1;
	assign last = left_next == 16'd0;
	assign index_next = gate_index_q + 16'd1;
	assign close = last && (index_next >= gates_q);

	assign push = accept && (is_gate ? open_q : !open_q);

	always_comb begin
		push_cmd.item = in_data;
		push_cmd.hdr = pkt_start;
		push_cmd.first = gate_index_q == 16'd0;
		push_cmd.count = count;
		push_cmd.last = last;
		push_cmd.close = close;
		if (!is_gate) begin
			push_cmd.kind = iqp_pkg::CMD_DESC;
		end else if (pkt_start && end_of_pulse) begin
			// gate count lowered mid-pulse: this gate only closes the pulse
			push_cmd.kind = iqp_pkg::CMD_CLOSE;
		end else begin
			push_cmd.kind = iqp_pkg::CMD_GATE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_index_q <= '0;
			left_q <= '0;
			open_q <= 1'b0;
		end else if (accept) begin
			if (!is_gate && !open_q) begin
				gate_index_q <= '0;
				left_q <= '0;
				open_q <= gates_q != 16'd0;
			end else if (is_gate && open_q) begin
				if (pkt_start && end_of_pulse) begin
					open_q <= 1'b0;
				end else begin
					left_q <= left_next;
					gate_index_q <= index_next;
					if (close) begin
						open_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

>>> sv/iqp_back.sv
`timescale 1ns / 1ps
// iqp_back: executes queue commands; holds pulse descriptor and counters,
// emits header and IQ words into the output register. Depends on iqp_pkg.
module iqp_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input iqp_pkg::cmd_t head,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output iqp_pkg::out_t out_data
);

	typedef struct packed {
		logic [15:0] msg_type;
		logic [31:0] reserved;
		logic [31:0] flags;
		logic [31:0] beam_index;
		logic [63:0] sample;
		logic [63:0] pulse;
		logic [63:0] seconds;
		logic [31:0] nanoseconds;
		logic [31:0] start_index;
		logic [31:0] u;
		logic [31:0] v;
		logic [63:0] dwell;
		logic [31:0] beam;
		logic [31:0] visit;
		logic [31:0] count;
		logic [95:0] spare;
	} hdr_t;

	typedef logic [iqp_pkg::HDR_WORDS-1:0][15:0] hdr_words_t;

	localparam logic [5:0] I_POS = 6'(iqp_pkg::HDR_WORDS);
	localparam logic [5:0] Q_POS = 6'(iqp_pkg::HDR_WORDS + 1);
	localparam logic [5:0] TOP_POS = 6'(iqp_pkg::HDR_WORDS - 1);

	iqp_pkg::in_t held_q;
	logic [63:0] sample_q;
	logic [63:0] pulse_q;
	logic [5:0] idx_q;
	logic out_valid_q;
	iqp_pkg::out_t out_q;

	hdr_t hdr;
	hdr_words_t hdr_words;
	logic load;
	logic [5:0] pos;
	logic gate_go;
	logic [15:0] word;

	always_comb begin
		hdr.msg_type = iqp_pkg::MSG_TYPE;
		hdr.reserved = '0;
		hdr.flags = {29'd0, head.first, held_q.transmit_h == held_q.copolar_receive,
			held_q.transmit_h};
		hdr.beam_index = iqp_pkg::BEAM_INDEX;
		hdr.sample = sample_q;
		hdr.pulse = pulse_q;
		hdr.seconds = held_q.seconds;
		hdr.nanoseconds = {2'b00, held_q.nanoseconds};
		hdr.start_index = '0;
		hdr.u = held_q.u_bits;
		hdr.v = held_q.v_bits;
		hdr.dwell = held_q.dwell_number;
		hdr.beam = {16'd0, held_q.beam_in_dwell};
		hdr.visit = {16'd0, held_q.visit_in_beam};
		hdr.count = {16'd0, head.count};
		hdr.spare = '0;
	end

	assign hdr_words = hdr_words_t'(hdr);

	assign load = !out_valid_q || out_ready;
	// gates without a header start at the I word
	assign pos = head.hdr ? idx_q : idx_q + I_POS;
	assign gate_go = !q_empty && head.kind == iqp_pkg::CMD_GATE && load;
	assign pop = !q_empty && (head.kind != iqp_pkg::CMD_GATE || (load && pos == Q_POS));

	always_comb begin
		if (pos == I_POS) begin
			word = head.item.i_value;
		end else if (pos == Q_POS) begin
			word = head.item.q_value;
		end else begin
			word = hdr_words[TOP_POS - pos];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			sample_q <= '0;
			pulse_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= gate_go;
			end
			if (gate_go) begin
				if (pos == Q_POS) begin
					idx_q <= '0;
					sample_q <= sample_q + 64'd1;
					if (head.close) begin
						pulse_q <= pulse_q + 64'd1;
					end
				end else begin
					idx_q <= idx_q + 6'd1;
				end
			end
			if (!q_empty) begin
				case (head.kind)
					iqp_pkg::CMD_DESC: held_q <= head.item;
					iqp_pkg::CMD_CLOSE: pulse_q <= pulse_q + 64'd1;
					default: held_q <= held_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gate_go) begin
			out_q.word <= word;
			out_q.last_in_packet <= (pos == Q_POS) && head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

>>> tb/sv/iqp_packet_checker.sv
`timescale 1ns / 1ps
// iqp_packet_checker: predicts the datagram word stream of the IQ pulse packetizer from
// accepted input transactions and register writes, and compares every output transaction.
// Depends on iqp_pkg for the channel payload types and the header constants.
module iqp_packet_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input iqp_pkg::in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input iqp_pkg::out_t out_data,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data,
	output int fail_count,
	output int pending,
	output int words_seen,
	output int packets_seen
);

	logic [15:0] gates_cfg;
	logic [15:0] max_bytes;
	logic [63:0] sample_no;
	logic [63:0] pulse_no;
	logic [63:0] held_sec;
	logic [29:0] held_ns;
	logic [63:0] held_dwell;
	logic [15:0] held_beam;
	logic [15:0] held_visit;
	logic [31:0] held_u;
	logic [31:0] held_v;
	logic held_txh;
	logic held_copol;
	logic [15:0] gate_idx;
	logic [15:0] gates_left;
	logic pulse_open;
	iqp_pkg::out_t expected_words[$];
	iqp_pkg::out_t head_word;

	task automatic push_word(input logic [15:0] w, input logic last);
		iqp_pkg::out_t e;
		e.word = w;
		e.last_in_packet = last;
		expected_words = {expected_words, e};
	endtask

	task automatic push32(input logic [31:0] v);
		push_word(v[31:16], 1'b0);
		push_word(v[15:0], 1'b0);
	endtask

	task automatic push64(input logic [63:0] v);
		push32(v[63:32]);
		push32(v[31:0]);
	endtask

	task automatic frame_transaction(input iqp_pkg::in_t it);
		int unsigned max_gates;
		int unsigned packets;
		int unsigned per;
		int unsigned rem;
		logic [31:0] flags;
		if (it.kind == iqp_pkg::KIND_DESC) begin
			if (!pulse_open) begin
				held_sec = it.seconds;
				held_ns = it.nanoseconds;
				held_dwell = it.dwell_number;
				held_beam = it.beam_in_dwell;
				held_visit = it.visit_in_beam;
				held_u = it.u_bits;
				held_v = it.v_bits;
				held_txh = it.transmit_h;
				held_copol = it.copolar_receive;
				gate_idx = '0;
				gates_left = '0;
				pulse_open = (gates_cfg != 16'd0);
			end
		end else if (pulse_open) begin
			if (gates_left == 16'd0 && gate_idx >= gates_cfg) begin
				// gate count lowered below what was already sent: this gate only closes the pulse
				pulse_open = 1'b0;
				pulse_no++;
			end else begin
				if (gates_left == 16'd0) begin
					// split is taken from the register values current at packet start
					if (max_bytes < iqp_pkg::HDR_BYTES + iqp_pkg::GATE_BYTES)
						max_gates = 1;
					else
						max_gates = 32'((max_bytes - iqp_pkg::HDR_BYTES)
							/ iqp_pkg::GATE_BYTES);
					packets = 32'(gates_cfg) / max_gates + 1;
					per = (32'(gates_cfg) - 1) / packets + 1;
					rem = 32'(gates_cfg) - 32'(gate_idx);
					gates_left = (per < rem) ? per[15:0] : rem[15:0];
					flags = {29'd0, gate_idx == 16'd0, held_txh == held_copol, held_txh};
					push_word(iqp_pkg::MSG_TYPE, 1'b0);
					push_word(16'd0, 1'b0);
					push_word(16'd0, 1'b0);
					push32(flags);
					push32(iqp_pkg::BEAM_INDEX);
					push64(sample_no);
					push64(pulse_no);
					push64(held_sec);
					push32({2'b00, held_ns});
					push32(32'd0);
					push32(held_u);
					push32(held_v);
					push64(held_dwell);
					push32({16'd0, held_beam});
					push32({16'd0, held_visit});
					push32({16'd0, gates_left});
					push32(32'd0);
					push32(32'd0);
					push32(32'd0);
				end
				gates_left--;
				push_word(it.i_value, 1'b0);
				push_word(it.q_value, gates_left == 16'd0);
				gate_idx++;
				sample_no++;
				if (gates_left == 16'd0 && gate_idx >= gates_cfg) begin
					pulse_open = 1'b0;
					pulse_no++;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gates_cfg = iqp_pkg::GATES_RESET;
			max_bytes = iqp_pkg::MAX_BYTES_RESET;
			sample_no = '0;
			pulse_no = '0;
			held_sec = '0;
			held_ns = '0;
			held_dwell = '0;
			held_beam = '0;
			held_visit = '0;
			held_u = '0;
			held_v = '0;
			held_txh = 1'b0;
			held_copol = 1'b0;
			gate_idx = '0;
			gates_left = '0;
			pulse_open = 1'b0;
			expected_words.delete();
			fail_count = 0;
			pending = 0;
			words_seen = 0;
			packets_seen = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == iqp_pkg::CFG_GATES)
					gates_cfg = cfg_data;
				else
					max_bytes = cfg_data;
			end
			if (in_valid && in_ready)
				frame_transaction(in_data);
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected transaction, expected none, actual word %h last %b",
						$time, out_data.word, out_data.last_in_packet);
				end else begin
					head_word = expected_words.pop_front();
					if (out_data.word !== head_word.word) begin
						fail_count++;
						$display("%0t: word mismatch, expected %h, actual %h",
							$time, head_word.word, out_data.word);
					end
					if (out_data.last_in_packet !== head_word.last_in_packet) begin
						fail_count++;
						$display("%0t: last_in_packet mismatch, expected %b, actual %b",
							$time, head_word.last_in_packet, out_data.last_in_packet);
					end
					words_seen++;
					if (head_word.last_in_packet)
						packets_seen++;
				end
			end
			pending = expected_words.size();
		end
	end

endmodule

>>> tb/sv/tb_iq_pulse_udp_packetizer.sv
`timescale 1ns / 1ps
// tb_iq_pulse_udp_packetizer: drives descriptor and gate transactions and register writes
// into the packetizer with random idling on both channels; iqp_packet_checker scores output.
// Depends on iqp_pkg, iq_pulse_udp_packetizer and iqp_packet_checker.
module tb_iq_pulse_udp_packetizer;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = 60;
	localparam int RANDOM_ITEMS = 230;
	localparam int QUIET_AFTER = 180;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	iqp_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	iqp_pkg::out_t out_data;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [15:0] cfg_data;

	int fail_count;
	int pending;
	int words_seen;
	int packets_seen;
	int stall_cycles;
	int items_sent;
	int phases;
	logic sender_gaps;
	logic receiver_gaps;
	logic hold_armed;
	logic hold_taken;

	iq_pulse_udp_packetizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	iqp_packet_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending),
		.words_seen(words_seen),
		.packets_seen(packets_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: random stall bursts, plus one long hold-off to back the block up
	initial begin
		out_ready = 1'b0;
		hold_taken = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_armed && !hold_taken) begin
				hold_taken = 1'b1;
				out_ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d words still expected",
					$time, stall_cycles, pending);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic iqp_pkg::in_t random_desc();
		iqp_pkg::in_t it;
		it.kind = iqp_pkg::KIND_DESC;
		it.seconds = {$urandom, $urandom};
		it.nanoseconds = 30'($urandom_range(0, 999999999));
		it.dwell_number = {$urandom, $urandom};
		it.beam_in_dwell = 16'($urandom_range(0, 65535));
		it.visit_in_beam = 16'($urandom_range(0, 65535));
		it.u_bits = $urandom;
		it.v_bits = $urandom;
		it.transmit_h = 1'($urandom_range(0, 1));
		it.copolar_receive = 1'($urandom_range(0, 1));
		it.i_value = 16'($urandom_range(0, 65535));
		it.q_value = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	// gate fields random, descriptor fields left random too since a gate ignores them
	function automatic iqp_pkg::in_t random_gate();
		iqp_pkg::in_t it;
		it = random_desc();
		it.kind = iqp_pkg::KIND_GATE;
		return it;
	endfunction

	task automatic send_item(input iqp_pkg::in_t it);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_data = it;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input iqp_pkg::cfg_idx_t idx, input logic [15:0] value);
		cfg_index = idx;
		cfg_data = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// drain the output, then give dropped gates and descriptors time to clear the block
	task automatic settle();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		iqp_pkg::in_t it;
		int gates;
		int max_sel;
		int pulses;
		int n_gates;
		int framed;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = iqp_pkg::CFG_GATES;
		cfg_data = '0;
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		hold_armed = 1'b0;
		items_sent = 0;
		phases = 0;
		framed = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// short pulse at the reset packet size; stray gate before it, repeated descriptor inside
		write_reg(iqp_pkg::CFG_GATES, 16'd3);
		send_item(random_gate());
		it = random_desc();
		it.seconds = 64'h8000_0000_0000_0000;
		it.nanoseconds = 30'd999999999;
		it.dwell_number = '1;
		it.beam_in_dwell = 16'hFFFF;
		it.visit_in_beam = 16'h0000;
		it.u_bits = '1;
		it.v_bits = '0;
		it.transmit_h = 1'b1;
		it.copolar_receive = 1'b1;
		send_item(it);
		send_item(random_desc());
		it = random_gate();
		it.i_value = 16'h8000;
		it.q_value = 16'h7FFF;
		send_item(it);
		it = random_gate();
		it.i_value = 16'h7FFF;
		it.q_value = 16'h8000;
		send_item(it);
		it = random_gate();
		it.i_value = 16'h0000;
		it.q_value = 16'hFFFF;
		send_item(it);
		send_item(random_gate());
		settle();

		// maximum gate count, one gate per packet
		write_reg(iqp_pkg::CFG_MAX_BYTES, 16'd90);
		write_reg(iqp_pkg::CFG_GATES, 16'hFFFF);
		it = random_desc();
		it.seconds = 64'h7FFF_FFFF_FFFF_FFFF;
		it.nanoseconds = 30'd0;
		it.dwell_number = '0;
		it.beam_in_dwell = 16'h0000;
		it.visit_in_beam = 16'hFFFF;
		it.u_bits = '0;
		it.v_bits = '1;
		it.transmit_h = 1'b0;
		it.copolar_receive = 1'b1;
		send_item(it);
		repeat (3) send_item(random_gate());
		settle();

		// gate count lowered under gates already sent: next gate closes, the one after drops
		write_reg(iqp_pkg::CFG_GATES, 16'd2);
		send_item(random_gate());
		send_item(random_gate());
		settle();

		// zero gates per pulse: descriptor latched, no pulse opens
		write_reg(iqp_pkg::CFG_GATES, 16'd0);
		write_reg(iqp_pkg::CFG_MAX_BYTES, 16'd0);
		it = random_desc();
		it.transmit_h = 1'b0;
		it.copolar_receive = 1'b0;
		send_item(it);
		send_item(random_gate());
		settle();

		write_reg(iqp_pkg::CFG_GATES, 16'd4);
		write_reg(iqp_pkg::CFG_MAX_BYTES, 16'd89);
		it = random_desc();
		it.transmit_h = 1'b1;
		it.copolar_receive = 1'b0;
		send_item(it);
		repeat (4) send_item(random_gate());
		settle();

		write_reg(iqp_pkg::CFG_GATES, 16'd5);
		write_reg(iqp_pkg::CFG_MAX_BYTES, 16'd65507);
		send_item(random_desc());
		repeat (5) send_item(random_gate());
		settle();

		while (framed < RANDOM_ITEMS) begin
			phases++;
			if (framed >= QUIET_AFTER) begin
				sender_gaps = 1'b0;
				receiver_gaps = 1'b0;
			end
			if (phases == 1) begin
				gates = 20;
				hold_armed = 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				gates = $urandom_range(25, 60);
			end else begin
				gates = $urandom_range(1, 16);
			end
			case ($urandom_range(0, 9))
				0: max_sel = $urandom_range(0, 89);
				1: max_sel = $urandom_range(90, 65507);
				default: max_sel = 90 + $urandom_range(0, 40);
			endcase
			write_reg(iqp_pkg::CFG_GATES, gates[15:0]);
			write_reg(iqp_pkg::CFG_MAX_BYTES, max_sel[15:0]);
			pulses = $urandom_range(1, 3);
			repeat (pulses) begin
				if ($urandom_range(0, 7) == 0)
					send_item(random_gate());
				send_item(random_desc());
				// now and then a pulse is cut short and the following ones run into it
				n_gates = ($urandom_range(0, 9) == 0) ? $urandom_range(0, gates) : gates;
				framed += n_gates + 1;
				repeat (n_gates) begin
					send_item(random_gate());
					if ($urandom_range(0, 19) == 0)
						send_item(random_desc());
				end
			end
			settle();
		end

		$display("Sent %0d input transactions: directed cases, then %0d random register settings.",
			items_sent, phases);
		$display("Checked %0d output words in %0d datagrams.", words_seen, packets_seen);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> iq_pulse_udp_packetizer.f
sv/iqp_pkg.sv
sv/iqp_div.sv
sv/iqp_fifo.sv
sv/iqp_front.sv
sv/iqp_back.sv
sv/iq_pulse_udp_packetizer.sv
tb/sv/iqp_packet_checker.sv
tb/sv/tb_iq_pulse_udp_packetizer.sv
